### design/bnf_pkg.sv
// Shared types, widths and codes for the batch normalization forward core.
// Depends on nothing; bnf_intf, bnf_ctrl, bnf_dp, the top and bnf_checker use scoped names.
package bnf_pkg;

    localparam int MAX_BATCH_DEF = 64;
    localparam int MAX_FEAT_DEF  = 64;

    localparam int DATA_W    = 16;
    localparam int FEAT_W    = 6;
    localparam int POS_W     = 6;
    localparam int FCMP_W    = 11;
    localparam int NW        = 7;
    localparam int SUM_W     = 22;
    localparam int SQS_W     = 37;
    localparam int DIV_W     = NW + SQS_W;
    localparam int SQ_IN_W   = 48;
    localparam int SQ_OUT_W  = SQ_IN_W / 2;
    localparam int VE_W      = SQ_IN_W - 16;
    localparam int DEN_W     = NW + SQ_OUT_W;
    localparam int T_W       = 24;

    localparam logic [DATA_W-1:0] EPS_RESET = 16'd1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_PARAM  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_VPREP,
        ST_VDIV,
        ST_VWAIT,
        ST_SQRT,
        ST_SWAIT,
        ST_DEN,
        ST_READ,
        ST_MULA,
        ST_MULB,
        ST_DIV,
        ST_DWAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic clr_we;
        logic var_prep;
        logic div_start;
        logic div_var;
        logic sq_start;
        logic den_load;
        logic mul_a;
        logic mul_b;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic close;
        logic clr_last;
        logic div_done;
        logic sq_done;
        logic den_zero;
        logic idx_last;
        logic out_free;
    } t_status;

endpackage

### design/bnf_intf.sv
// Valid/ready channel interfaces: sample/parameter input, result output, epsilon write.
// Payload widths come from bnf_pkg.
interface bnf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 operation;
    logic [bnf_pkg::FEAT_W-1:0]           feature_index;
    logic signed [bnf_pkg::DATA_W-1:0]    sample_value;
    logic                                 end_of_row;
    logic signed [bnf_pkg::DATA_W-1:0]    gamma_value;
    logic signed [bnf_pkg::DATA_W-1:0]    beta_value;

    modport source (output valid, operation, feature_index, sample_value, end_of_row,
                    gamma_value, beta_value, input ready);
    modport sink   (input valid, operation, feature_index, sample_value, end_of_row,
                    gamma_value, beta_value, output ready);
endinterface

interface bnf_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bnf_pkg::DATA_W-1:0]    normalized_value;
    logic [bnf_pkg::POS_W-1:0]            sample_position;
    logic [bnf_pkg::FEAT_W-1:0]           row_feature;
    logic                                 row_done;

    modport source (output valid, normalized_value, sample_position, row_feature, row_done,
                    input ready);
    modport sink   (input valid, normalized_value, sample_position, row_feature, row_done,
                    output ready);
endinterface

interface bnf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bnf_pkg::DATA_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### design/bnf_ctrl.sv
// Sequencer for the core: clearing pass, row load, statistics and per-sample results.
// Depends on bnf_pkg for the state enum and the command/status structs.
module bnf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bnf_pkg::t_status i_status,
    output bnf_pkg::t_cmd    o_cmd
);

    bnf_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bnf_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bnf_pkg::ST_CLEAR: if (i_status.clr_last) n_state = bnf_pkg::ST_LOAD;
            bnf_pkg::ST_LOAD:  if (i_status.close) n_state = bnf_pkg::ST_VPREP;
            bnf_pkg::ST_VPREP: n_state = bnf_pkg::ST_VDIV;
            bnf_pkg::ST_VDIV:  n_state = bnf_pkg::ST_VWAIT;
            bnf_pkg::ST_VWAIT: if (i_status.div_done) n_state = bnf_pkg::ST_SQRT;
            bnf_pkg::ST_SQRT:  n_state = bnf_pkg::ST_SWAIT;
            bnf_pkg::ST_SWAIT: if (i_status.sq_done) n_state = bnf_pkg::ST_DEN;
            bnf_pkg::ST_DEN:   n_state = bnf_pkg::ST_READ;
            bnf_pkg::ST_READ:  n_state = bnf_pkg::ST_MULA;
            bnf_pkg::ST_MULA:  n_state = bnf_pkg::ST_MULB;
            bnf_pkg::ST_MULB: begin
                n_state = i_status.den_zero ? bnf_pkg::ST_EMIT : bnf_pkg::ST_DIV;
            end
            bnf_pkg::ST_DIV:   n_state = bnf_pkg::ST_DWAIT;
            bnf_pkg::ST_DWAIT: if (i_status.div_done) n_state = bnf_pkg::ST_EMIT;
            bnf_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.idx_last ? bnf_pkg::ST_LOAD : bnf_pkg::ST_READ;
                end
            end
            default:           n_state = bnf_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            bnf_pkg::ST_CLEAR: o_cmd.clr_we = 1'b1;
            bnf_pkg::ST_LOAD:  o_cmd.in_ready = 1'b1;
            bnf_pkg::ST_VPREP: o_cmd.var_prep = 1'b1;
            bnf_pkg::ST_VDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_var   = 1'b1;
            end
            bnf_pkg::ST_SQRT:  o_cmd.sq_start = 1'b1;
            bnf_pkg::ST_DEN:   o_cmd.den_load = 1'b1;
            bnf_pkg::ST_MULA:  o_cmd.mul_a = 1'b1;
            bnf_pkg::ST_MULB:  o_cmd.mul_b = 1'b1;
            bnf_pkg::ST_DIV:   o_cmd.div_start = 1'b1;
            bnf_pkg::ST_EMIT:  o_cmd.emit = i_status.out_free;
            default:           o_cmd = '0;
        endcase
    end

endmodule

### design/bnf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; widths set by its parameter.
module bnf_div #(
    parameter int W = 44
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot
);

    localparam int CNTW = $clog2(W + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [W-1:0]    r_rem, n_rem;
    logic [W-1:0]    r_quot, n_quot;
    logic [W-1:0]    r_div;
    logic [W:0]      v_sh;

    always_comb begin
        v_sh = {r_rem, r_quot[W-1]};
        if (v_sh >= {1'b0, r_div}) begin
            n_rem  = W'(v_sh - {1'b0, r_div});
            n_quot = {r_quot[W-2:0], 1'b1};
        end else begin
            n_rem  = W'(v_sh);
            n_quot = {r_quot[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### design/bnf_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Standalone; widths set by its parameter.
module bnf_sqrt #(
    parameter int W = 48
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_radicand,
    output logic           o_done,
    output logic [W/2-1:0] o_root
);

    localparam int RTW  = W / 2;
    localparam int RW   = RTW + 2;
    localparam int CNTW = $clog2(RTW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [W-1:0]    r_rad;
    logic [RW-1:0]   r_rem, n_rem;
    logic [RTW-1:0]  r_root, n_root;
    logic [RW+1:0]   v_rem, v_trial;

    always_comb begin
        v_rem   = {r_rem, r_rad[W-1:W-2]};
        v_trial = (RW + 2)'({r_root, 2'b01});
        if (v_rem >= v_trial) begin
            n_rem  = RW'(v_rem - v_trial);
            n_root = {r_root[RTW-2:0], 1'b1};
        end else begin
            n_rem  = RW'(v_rem);
            n_root = {r_root[RTW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(RTW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### design/bnf_dp.sv
// Datapath: sample buffer, parameter table, row statistics, shared divider, square root
// and output register. Depends on bnf_pkg, bnf_intf, bnf_div and bnf_sqrt.
module bnf_dp #(
    parameter int MAX_BATCH    = bnf_pkg::MAX_BATCH_DEF,
    parameter int MAX_FEATURES = bnf_pkg::MAX_FEAT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bnf_in_if.sink           i_in,
    bnf_out_if.source        o_out,
    bnf_cfg_if.sink          i_cfg,
    input  bnf_pkg::t_cmd    i_cmd,
    output bnf_pkg::t_status o_status
);

    localparam int BAW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int CW  = $clog2(MAX_BATCH + 1);
    localparam int FAW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam logic signed [bnf_pkg::DIV_W+1:0] Y_MAX = 32767;
    localparam logic signed [bnf_pkg::DIV_W+1:0] Y_MIN = -32768;

    // storage
    logic [bnf_pkg::DATA_W-1:0]          buf_mem [MAX_BATCH];
    logic [2*bnf_pkg::DATA_W-1:0]        tab_mem [MAX_FEATURES];
    logic signed [bnf_pkg::DATA_W-1:0]   r_buf_q;
    logic [2*bnf_pkg::DATA_W-1:0]        r_tab_q;

    // row state
    logic [CW-1:0]                       r_count;
    logic signed [bnf_pkg::SUM_W-1:0]    r_sum;
    logic [bnf_pkg::SQS_W-1:0]           r_sumsq;
    logic [bnf_pkg::DATA_W-1:0]          r_eps;
    logic [bnf_pkg::FEAT_W-1:0]          r_feat;
    logic                                r_feat_ok;
    logic [FAW-1:0]                      r_clr;
    logic [BAW-1:0]                      r_idx;

    // statistics and per-sample terms
    logic [bnf_pkg::DIV_W-1:0]           r_pa, r_pb;
    logic [2*bnf_pkg::NW-1:0]            r_nn;
    logic [bnf_pkg::DEN_W-1:0]           r_den;
    logic signed [bnf_pkg::DATA_W-1:0]   r_g, r_b;
    logic signed [bnf_pkg::T_W-1:0]      r_t;
    logic                                r_neg;
    logic [bnf_pkg::DIV_W-1:0]           r_mag;

    // output register
    logic                                r_out_valid;
    logic signed [bnf_pkg::DATA_W-1:0]   r_out_value;
    logic [bnf_pkg::POS_W-1:0]           r_out_pos;
    logic [bnf_pkg::FEAT_W-1:0]          r_out_feat;
    logic                                r_out_done;

    logic                                v_acc, v_load, v_pwrite, v_in_feat_ok, v_room;
    logic [bnf_pkg::NW-1:0]              v_n;
    logic signed [bnf_pkg::NW:0]         v_ns;
    logic signed [2*bnf_pkg::DATA_W-1:0] v_xx;
    logic signed [2*bnf_pkg::SUM_W-1:0]  v_ss;
    logic signed [bnf_pkg::T_W-1:0]      v_nx;
    logic signed [bnf_pkg::DIV_W-1:0]    v_p, v_p4;
    logic [bnf_pkg::DIV_W:0]             v_ve;
    logic signed [bnf_pkg::DIV_W+1:0]    v_q, v_y;
    logic signed [bnf_pkg::DATA_W-1:0]   v_sat;
    logic [bnf_pkg::DIV_W-1:0]           v_dividend, v_divisor, div_q;
    logic                                div_done, sq_done;
    logic [bnf_pkg::SQ_OUT_W-1:0]        sq_root;
    logic [bnf_pkg::SQ_IN_W-1:0]         v_rad;
    logic                                v_idx_last, v_out_free;
    logic [FAW-1:0]                      v_tab_waddr;
    logic [2*bnf_pkg::DATA_W-1:0]        v_tab_wdata;

    assign v_acc        = i_in.valid && i_cmd.in_ready;
    assign v_load       = v_acc && (i_in.operation == bnf_pkg::OP_SAMPLE);
    assign v_in_feat_ok = {{(bnf_pkg::FCMP_W - bnf_pkg::FEAT_W){1'b0}}, i_in.feature_index}
                          < bnf_pkg::FCMP_W'(MAX_FEATURES);
    assign v_pwrite     = v_acc && (i_in.operation == bnf_pkg::OP_PARAM) && v_in_feat_ok;
    assign v_room       = r_count < CW'(MAX_BATCH);
    assign v_n          = bnf_pkg::NW'(r_count);
    assign v_ns         = {1'b0, v_n};
    assign v_xx         = i_in.sample_value * i_in.sample_value;
    assign v_ss         = r_sum * r_sum;
    assign v_nx         = v_ns * r_buf_q;
    assign v_p          = r_t * r_g;
    assign v_p4         = v_p <<< 4;
    assign v_idx_last   = (CW'(r_idx) + CW'(1)) == r_count;
    assign v_out_free   = !r_out_valid || o_out.ready;

    // buffer: write during load, registered read at the running position
    always_ff @(posedge i_clk) begin
        if (v_load && v_room) begin
            buf_mem[BAW'(r_count)] <= i_in.sample_value;
        end
        r_buf_q <= buf_mem[r_idx];
    end

    // gamma/beta table: clearing pass after reset, then parameter writes
    assign v_tab_waddr = i_cmd.clr_we ? r_clr : FAW'(i_in.feature_index);
    assign v_tab_wdata = i_cmd.clr_we ? '0 : {i_in.gamma_value, i_in.beta_value};

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we || v_pwrite) begin
            tab_mem[v_tab_waddr] <= v_tab_wdata;
        end
        r_tab_q <= tab_mem[FAW'(r_feat)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_eps       <= bnf_pkg::EPS_RESET;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_eps <= i_cfg.data;
            end
            if (i_cmd.clr_we) begin
                r_clr <= r_clr + FAW'(1);
            end
            if (v_load && v_room) begin
                r_count <= r_count + CW'(1);
                r_sum   <= r_sum + bnf_pkg::SUM_W'(i_in.sample_value);
                r_sumsq <= r_sumsq + bnf_pkg::SQS_W'(unsigned'(v_xx));
            end
            if (i_cmd.emit && v_idx_last) begin
                r_count <= '0;
                r_sum   <= '0;
                r_sumsq <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // shared divider operands: variance quotient, then one rounded quotient per sample with a nonzero denominator
    always_comb begin
        if (i_cmd.div_var) begin
            v_dividend = r_pa - r_pb;
            v_divisor  = bnf_pkg::DIV_W'(r_nn);
        end else begin
            v_dividend = bnf_pkg::DIV_W'({r_mag, 1'b0}) + bnf_pkg::DIV_W'(r_den);
            v_divisor  = bnf_pkg::DIV_W'({r_den, 1'b0});
        end
    end

    assign v_ve  = {1'b0, div_q} + (bnf_pkg::DIV_W + 1)'(r_eps);
    assign v_rad = {v_ve[bnf_pkg::VE_W-1:0], 16'h0000};

    bnf_div #(.W(bnf_pkg::DIV_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (v_dividend),
        .i_divisor  (v_divisor),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    bnf_sqrt #(.W(bnf_pkg::SQ_IN_W)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sq_start),
        .i_radicand (v_rad),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    always_comb begin
        if (r_den == '0) begin
            v_q = '0;
        end else if (r_neg) begin
            v_q = -signed'({2'b00, div_q});
        end else begin
            v_q = signed'({2'b00, div_q});
        end
        v_y = v_q + r_b;
        if (v_y > Y_MAX) begin
            v_sat = 16'sh7fff;
        end else if (v_y < Y_MIN) begin
            v_sat = -16'sh8000;
        end else begin
            v_sat = bnf_pkg::DATA_W'(v_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_load && i_in.end_of_row) begin
            r_feat    <= i_in.feature_index;
            r_feat_ok <= v_in_feat_ok;
        end
        if (i_cmd.var_prep) begin
            r_pa <= v_n * r_sumsq;
            r_pb <= unsigned'(v_ss);
            r_nn <= v_n * v_n;
        end
        if (i_cmd.den_load) begin
            r_den <= v_n * sq_root;
            r_g   <= r_feat_ok ? signed'(r_tab_q[2*bnf_pkg::DATA_W-1:bnf_pkg::DATA_W]) : '0;
            r_b   <= r_feat_ok ? signed'(r_tab_q[bnf_pkg::DATA_W-1:0]) : '0;
            r_idx <= '0;
        end
        if (i_cmd.mul_a) begin
            r_t <= v_nx - r_sum;
        end
        if (i_cmd.mul_b) begin
            r_neg <= v_p4[bnf_pkg::DIV_W-1];
            r_mag <= v_p4[bnf_pkg::DIV_W-1] ? unsigned'(-v_p4) : unsigned'(v_p4);
        end
        if (i_cmd.emit) begin
            r_out_value <= v_sat;
            r_out_pos   <= bnf_pkg::POS_W'(r_idx);
            r_out_feat  <= r_feat;
            r_out_done  <= v_idx_last;
            r_idx       <= r_idx + BAW'(1);
        end
    end

    // hold off epsilon writes while reset is applied
    assign i_in.ready  = i_cmd.in_ready;
    assign i_cfg.ready = i_rst_n;

    assign o_out.valid            = r_out_valid;
    assign o_out.normalized_value = r_out_value;
    assign o_out.sample_position  = r_out_pos;
    assign o_out.row_feature      = r_out_feat;
    assign o_out.row_done         = r_out_done;

    always_comb begin
        o_status.close    = v_load && i_in.end_of_row;
        o_status.clr_last = r_clr == FAW'(MAX_FEATURES - 1);
        o_status.div_done = div_done;
        o_status.sq_done  = sq_done;
        o_status.den_zero = r_den == '0;
        o_status.idx_last = v_idx_last;
        o_status.out_free = v_out_free;
    end

endmodule

### design/batch_norm_forward_core.sv
// Loading: one sample or parameter item per cycle, while in the load state. A closing
// sample then starts the row statistics (variance divide on the shared divider, then
// square root) and one quotient per buffered sample when the denominator is nonzero.
// Reset is synchronous, active low; afterwards a clearing pass zeroes all MAX_FEATURES
// gamma/beta table entries, and no item is taken until it ends (epsilon writes are).
module batch_norm_forward_core #(
    parameter int MAX_BATCH    = bnf_pkg::MAX_BATCH_DEF,
    parameter int MAX_FEATURES = bnf_pkg::MAX_FEAT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bnf_in_if.sink    i_in,
    bnf_out_if.source o_out,
    bnf_cfg_if.sink   i_cfg
);

    // command and status between the sequencer and the datapath
    bnf_pkg::t_cmd    cmd;
    bnf_pkg::t_status status;

    // sequencer: clear the table, load a row, run statistics, emit one item per sample
    bnf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath: buffer, table, arithmetic units, output register
    bnf_dp #(
        .MAX_BATCH    (MAX_BATCH),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (i_cfg),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

### design/bnf_checker.sv
// Port-level checks for batch_norm_forward_core, attached by the bind below.
// Depends on bnf_pkg for the operation codes.
module bnf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_op,
    input logic                        i_in_last,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_out_done,
    input logic [bnf_pkg::POS_W-1:0]   i_out_pos,
    input logic [bnf_pkg::DATA_W-1:0]  i_out_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_value) && $stable(i_out_pos))
        else $error("stalled result item changed");

    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_op == bnf_pkg::OP_SAMPLE) && i_in_last
        |=> !i_in_ready)
        else $error("input taken right after a row closed");

    a_mid_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_done |-> !i_in_ready)
        else $error("input open while a row is still being emitted");

endmodule

bind batch_norm_forward_core bnf_checker u_bnf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.operation),
    .i_in_last   (i_in.end_of_row),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_done  (o_out.row_done),
    .i_out_pos   (o_out.sample_position),
    .i_out_value (o_out.normalized_value)
);
